// ===== hdl/swec_pkg.sv =====
// ----------------------------------------------------------------------------
// swec_pkg
// Shared constants for the sliding window event counter.
// ----------------------------------------------------------------------------
`default_nettype none

package swec_pkg;

  // field widths
  localparam int TS_W     = 32;
  localparam int STATUS_W = 2;

  // default ring size and reset window
  localparam int              RING_DEPTH_DEF = 1024;
  localparam logic [TS_W-1:0] WINDOW_RESET   = 32'd3000;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BACK = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/swec_ram.sv =====
// ----------------------------------------------------------------------------
// swec_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module swec_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hdl/sliding_window_event_counter.sv =====
// ----------------------------------------------------------------------------
// sliding_window_event_counter
// Counts the events whose timestamps fall in a sliding window ending at the
// newest timestamp. Timestamps are kept in a ring in one synchronous RAM.
// One result per input transfer. An item is accepted, then the oldest entry
// is compared, and every old entry dropped from the window adds a further
// step; the drop loop is a read of the oldest RAM entry per cycle. The
// block also waits in the compare step for as long as the previous result
// transfer is held by out_stall. A timestamp older than the last accepted one
// is rejected with status 1 and changes nothing; when the ring is full the
// event is not stored and status 2 is reported. The window register may be
// written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_event_counter #(
  parameter int RING_DEPTH = swec_pkg::RING_DEPTH_DEF,
  parameter int IDX_W      = $clog2(RING_DEPTH),
  parameter int CNT_W      = $clog2(RING_DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [swec_pkg::TS_W-1:0]     cfg_wr_data,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [swec_pkg::TS_W-1:0]     in_timestamp_ms,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [CNT_W-1:0]              out_event_count,
  output logic      [swec_pkg::STATUS_W-1:0] out_status
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CMP  = 1'b1;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

  // control state
  logic                          state_r,  state_nxt;
  logic [IDX_W-1:0]              head_r,   head_nxt;
  logic [IDX_W-1:0]              tail_r,   tail_nxt;
  logic [CNT_W-1:0]              count_r,  count_nxt;
  logic [swec_pkg::TS_W-1:0]     last_r,   last_nxt;
  logic                          have_r,   have_nxt;
  logic [swec_pkg::TS_W-1:0]     window_r, window_nxt;
  logic                          fwd_r,    fwd_nxt;
  logic                          rej_r,    rej_nxt;
  logic                          ovalid_r, ovalid_nxt;

  // payload registers
  logic [swec_pkg::TS_W-1:0]     ts_r,     ts_nxt;
  logic [swec_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [CNT_W-1:0]              ocount_r, ocount_nxt;
  logic [swec_pkg::STATUS_W-1:0] ostatus_r, ostatus_nxt;

  // ram port signals
  logic                          wr_en;
  logic [swec_pkg::TS_W-1:0]     rd_data;
  logic [swec_pkg::TS_W-1:0]     oldest;

  logic                          in_xfer;
  logic                          out_free;
  logic                          keep;
  logic                          done;
  logic                          backward;
  logic [IDX_W-1:0]              head_inc;
  logic [IDX_W-1:0]              tail_inc;

  assign in_xfer  = in_valid && (state_r == ST_IDLE);
  assign out_free = !ovalid_r || !out_stall;
  assign backward = have_r && (in_timestamp_ms < last_r);
  assign head_inc = (head_r == IDX_LAST) ? '0 : head_r + IDX_W'(1);
  assign tail_inc = (tail_r == IDX_LAST) ? '0 : tail_r + IDX_W'(1);

  // oldest entry, forwarded when it was written in the accept cycle
  assign oldest = fwd_r ? ts_r : rd_data;
  assign keep   = ({1'b0, oldest} + {1'b0, window_r}) >= {1'b0, ts_r};
  assign done   = rej_r || (count_r == '0) || keep;

  // ram write on an accepted, stored event
  assign wr_en = in_xfer && !backward && (count_r != CNT_FULL);

  swec_ram #(
    .WIDTH (swec_pkg::TS_W),
    .DEPTH (RING_DEPTH),
    .AW    (IDX_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (in_timestamp_ms),
    .rd_addr (head_nxt),
    .rd_data (rd_data)
  );

  // next-state logic
  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    last_nxt    = last_r;
    have_nxt    = have_r;
    window_nxt  = window_r;
    fwd_nxt     = 1'b0;
    rej_nxt     = rej_r;
    ovalid_nxt  = ovalid_r && out_stall;
    ts_nxt      = ts_r;
    status_nxt  = status_r;
    ocount_nxt  = ocount_r;
    ostatus_nxt = ostatus_r;

    if (cfg_wr_en) begin
      window_nxt = cfg_wr_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_CMP;
          ts_nxt    = in_timestamp_ms;
          rej_nxt   = backward;
          if (backward) begin
            status_nxt = swec_pkg::STATUS_BACK;
          end else begin
            last_nxt = in_timestamp_ms;
            have_nxt = 1'b1;
            if (count_r == CNT_FULL) begin
              status_nxt = swec_pkg::STATUS_FULL;
            end else begin
              status_nxt = swec_pkg::STATUS_OK;
              tail_nxt   = tail_inc;
              count_nxt  = count_r + CNT_W'(1);
              fwd_nxt    = (count_r == '0) && (head_r == tail_r);
            end
          end
        end
      end
      ST_CMP: begin
        if (!done) begin
          // drop the oldest entry and read the next one
          head_nxt  = head_inc;
          count_nxt = count_r - CNT_W'(1);
        end else if (out_free) begin
          ovalid_nxt  = 1'b1;
          ocount_nxt  = count_r;
          ostatus_nxt = status_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      last_r   <= '0;
      have_r   <= 1'b0;
      window_r <= swec_pkg::WINDOW_RESET;
      fwd_r    <= 1'b0;
      rej_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      last_r   <= last_nxt;
      have_r   <= have_nxt;
      window_r <= window_nxt;
      fwd_r    <= fwd_nxt;
      rej_r    <= rej_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ts_r      <= ts_nxt;
    status_r  <= status_nxt;
    ocount_r  <= ocount_nxt;
    ostatus_r <= ostatus_nxt;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = ovalid_r;
  assign out_event_count = ocount_r;
  assign out_status      = ostatus_r;

endmodule

`default_nettype wire

// ===== bench/tb_sliding_window_event_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_event_counter
// Self-checking bench for the sliding window event counter. A short directed
// table covers the window edges, repeated and backwards timestamps and the
// window extremes. Random phases follow, each under its own window setting:
// tiny windows, the reset window, a random window, a fill that runs the ring
// full, a sudden jump that empties a full ring, and a climb to the top of the
// timestamp range. Every result transfer is checked against a predictor kept here.
// ----------------------------------------------------------------------------

module tb_sliding_window_event_counter;

  localparam int RING_DEPTH = swec_pkg::RING_DEPTH_DEF;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int CYCLE_CAP  = 1_000_000;
  localparam logic [swec_pkg::TS_W-1:0] TS_MAX = '1;

  typedef struct packed {
    logic [CNT_W-1:0]              count;
    logic [swec_pkg::STATUS_W-1:0] status;
  } tally_t;

  typedef struct packed {
    bit                            wr_cfg;
    logic [swec_pkg::TS_W-1:0]     cfg_val;
    logic [swec_pkg::TS_W-1:0]     stamp;
    bit                            typed;
    logic [CNT_W-1:0]              count;
    logic [swec_pkg::STATUS_W-1:0] status;
  } plan_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_wr_en;
  logic [swec_pkg::TS_W-1:0]     cfg_wr_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [swec_pkg::TS_W-1:0]     in_timestamp_ms;
  logic                          out_valid;
  logic                          out_stall;
  logic [CNT_W-1:0]              out_event_count;
  logic [swec_pkg::STATUS_W-1:0] out_status;

  // predictor state
  logic [swec_pkg::TS_W-1:0] window_stamps [RING_DEPTH];
  int unsigned               oldest_idx = 0;
  int unsigned               free_idx   = 0;
  int unsigned               held_count = 0;
  logic [swec_pkg::TS_W-1:0] last_ms    = '0;
  bit                        seen_any   = 1'b0;
  logic [swec_pkg::TS_W-1:0] window_len = swec_pkg::WINDOW_RESET;

  tally_t      pending_tallies [$];
  plan_row_t   plan [$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned calm_left   = 0;
  logic [swec_pkg::TS_W-1:0] now_ms = '0;

  sliding_window_event_counter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_timestamp_ms (in_timestamp_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_count (out_event_count),
    .out_status      (out_status)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short idle spans, now and then a long one
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic note_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // count the events left in the window after one timestamp
  task automatic tally_event(input logic [swec_pkg::TS_W-1:0] ts, output tally_t res);
    bit scanning;
    res.status = swec_pkg::STATUS_OK;
    if (seen_any && ts < last_ms) begin
      res.status = swec_pkg::STATUS_BACK;
    end else begin
      last_ms  = ts;
      seen_any = 1'b1;
      if (held_count >= RING_DEPTH) begin
        res.status = swec_pkg::STATUS_FULL;
      end else begin
        window_stamps[free_idx] = ts;
        free_idx = (free_idx + 1) % RING_DEPTH;
        held_count++;
      end
      // drop from the oldest end while entry + window < ts
      scanning = 1'b1;
      while (scanning && held_count != 0) begin
        if ({1'b0, window_stamps[oldest_idx]} + {1'b0, window_len} >= {1'b0, ts}) begin
          scanning = 1'b0;
        end else begin
          oldest_idx = (oldest_idx + 1) % RING_DEPTH;
          held_count--;
        end
      end
    end
    res.count = CNT_W'(held_count);
  endtask

  // one input transfer, with a random gap ahead of it
  task automatic send_stamp(input logic [swec_pkg::TS_W-1:0] ts, input bit typed,
                            input logic [CNT_W-1:0] count,
                            input logic [swec_pkg::STATUS_W-1:0] status);
    tally_t      want;
    int unsigned gap;
    tally_event(ts, want);
    if (typed) begin
      want.count  = count;
      want.status = status;
    end
    pending_tallies = {pending_tallies, want};
    if (calm_left != 0) begin
      calm_left--;
      gap = 0;
    end else begin
      if ($urandom_range(99, 0) < 3) calm_left = 40;
      gap = pick_idle();
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_timestamp_ms <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold the input side until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_tallies.size() != 0) @(posedge clk);
  endtask

  task automatic set_window(input logic [swec_pkg::TS_W-1:0] value);
    drain_results();
    repeat (3) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    window_len  = value;
  endtask

  task automatic add_row(input bit wr_cfg, input logic [swec_pkg::TS_W-1:0] cfg_val,
                         input logic [swec_pkg::TS_W-1:0] stamp, input bit typed,
                         input logic [CNT_W-1:0] count,
                         input logic [swec_pkg::STATUS_W-1:0] status);
    plan_row_t row;
    row.wr_cfg  = wr_cfg;
    row.cfg_val = cfg_val;
    row.stamp   = stamp;
    row.typed   = typed;
    row.count   = count;
    row.status  = status;
    plan = {plan, row};
  endtask

  // random phase: mostly rising timestamps, some backwards noise
  task automatic run_phase(input logic [swec_pkg::TS_W-1:0] win, input int unsigned n,
                           input int unsigned step_max, input int unsigned jump_max,
                           input bit climb);
    int unsigned               good;
    logic [swec_pkg::TS_W-1:0] ts;
    longint unsigned           room;
    longint unsigned           step;
    set_window(win);
    good = 0;
    while (good < n) begin
      if (now_ms != 0 && $urandom_range(99, 0) < 7) begin
        ts = $urandom_range(now_ms - 1, 0);
      end else begin
        room = 64'(TS_MAX) - 64'(now_ms);
        if (climb) begin
          // spread the climb so the last event lands on the top timestamp
          if (good == n - 1) step = room;
          else step = 64'($urandom_range(32'(room / (n - good) * 2), 0));
        end else begin
          step = 64'($urandom_range(step_max, 0));
          if (jump_max != 0 && (good == 0 || $urandom_range(19, 0) == 0))
            step = 64'($urandom_range(jump_max, jump_max / 2));
        end
        if (step > room) step = room;
        ts     = now_ms + swec_pkg::TS_W'(step);
        now_ms = ts;
        good++;
      end
      send_stamp(ts, 1'b0, '0, swec_pkg::STATUS_OK);
      if ($urandom_range(149, 0) == 0) drain_results();
    end
  endtask

  // result stall pattern, with long stretches of no stall
  initial begin : stall_driver
    bit          stalling;
    int unsigned left;
    stalling  = 1'b0;
    left      = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      while (left == 0) begin
        stalling = !stalling;
        if (stalling) left = pick_idle();
        else if ($urandom_range(9, 0) == 0) left = $urandom_range(150, 50);
        else left = $urandom_range(8, 1);
      end
      left--;
      out_stall <= stalling;
    end
  end

  // check each result transfer against the oldest expectation
  always @(posedge clk) begin : result_check
    tally_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_tallies.size() == 0) begin
        note_mismatch($sformatf("result transfer with none expected, count %0d status %0d",
                                out_event_count, out_status));
      end else begin
        want = pending_tallies.pop_front();
        if (out_event_count !== want.count)
          note_mismatch($sformatf("event_count %0d, expected %0d",
                                  out_event_count, want.count));
        if (out_status !== want.status)
          note_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    in_valid        <= 1'b0;
    in_timestamp_ms <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows: window starts at its reset length
    add_row(1'b0, '0, 32'd0, 1'b1, 11'd1, swec_pkg::STATUS_OK);     // first event
    add_row(1'b0, '0, 32'd0, 1'b1, 11'd2, swec_pkg::STATUS_OK);     // equal timestamp
    add_row(1'b0, '0, 32'd3000, 1'b1, 11'd3, swec_pkg::STATUS_OK);  // lower bound is inclusive
    add_row(1'b0, '0, 32'd3001, 1'b1, 11'd2, swec_pkg::STATUS_OK);  // both zeros fall out
    add_row(1'b0, '0, 32'd3000, 1'b1, 11'd2, swec_pkg::STATUS_BACK); // backwards by one
    add_row(1'b0, '0, 32'd0, 1'b1, 11'd2, swec_pkg::STATUS_BACK);
    add_row(1'b0, '0, 32'd3001, 1'b1, 11'd3, swec_pkg::STATUS_OK);
    // zero window keeps equal stamps
    add_row(1'b1, 32'd0, 32'd3001, 1'b1, 11'd3, swec_pkg::STATUS_OK);
    add_row(1'b0, '0, 32'd3002, 1'b1, 11'd1, swec_pkg::STATUS_OK);
    // widest window drops nothing
    add_row(1'b1, TS_MAX, 32'h0010_0000, 1'b1, 11'd2, swec_pkg::STATUS_OK);
    add_row(1'b0, '0, 32'h0100_0000, 1'b1, 11'd3, swec_pkg::STATUS_OK);
    add_row(1'b1, 32'd1, 32'h0100_0001, 1'b1, 11'd2, swec_pkg::STATUS_OK);
    add_row(1'b0, '0, 32'h0100_0001, 1'b1, 11'd3, swec_pkg::STATUS_OK);
    add_row(1'b0, '0, 32'h0100_0002, 1'b1, 11'd3, swec_pkg::STATUS_OK);
    add_row(1'b0, '0, 32'h0100_0001, 1'b1, 11'd3, swec_pkg::STATUS_BACK);
    add_row(1'b1, swec_pkg::WINDOW_RESET, 32'h0100_0BB9, 1'b0, '0, swec_pkg::STATUS_OK);
    add_row(1'b0, '0, 32'h0100_0BBA, 1'b0, '0, swec_pkg::STATUS_OK);
    add_row(1'b0, '0, 32'h0100_0BBB, 1'b0, '0, swec_pkg::STATUS_OK);

    foreach (plan[i]) begin
      if (plan[i].wr_cfg) set_window(plan[i].cfg_val);
      send_stamp(plan[i].stamp, plan[i].typed, plan[i].count, plan[i].status);
      if (plan[i].stamp > now_ms) now_ms = plan[i].stamp;
    end

    // random phases
    run_phase(32'd0, 100, 3, 0, 1'b0);
    run_phase(32'd1, 100, 2, 0, 1'b0);
    run_phase(swec_pkg::WINDOW_RESET, 150, 400, 1 << 18, 1'b0);
    run_phase($urandom_range(1 << 20, 2), 100, 1 << 16, 1 << 22, 1'b0);
    // widest window with dense stamps runs the ring full
    run_phase(TS_MAX, 1080, 3, 0, 1'b0);
    // full ring meets a big jump under a tiny window
    run_phase(32'd7, 50, 3, 1 << 16, 1'b0);
    run_phase($urandom >> $urandom_range(31, 0), 60, 0, 0, 1'b1);

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
